// ===== src/lss_pkg.sv =====
`default_nettype none

package lss_pkg;

  localparam int unsigned MAX_BEAMS = 1024;
  // wide enough to hold MAX_BEAMS + 1
  localparam int unsigned CNT_W = $clog2(MAX_BEAMS + 2);

  localparam int unsigned VAL_W       = 16;
  localparam int unsigned MIN_RUN_W   = 11;
  localparam int unsigned RUN_FIRST_W = 10;
  localparam int unsigned RUN_END_W   = 11;

  // register index, byte address = 4 * index
  typedef enum logic [1:0] {
    REG_RANGE_LOW  = 2'd0,
    REG_RANGE_HIGH = 2'd1,
    REG_JUMP_LIMIT = 2'd2,
    REG_MIN_RUN    = 2'd3
  } lss_reg_e;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    val_t                 beam_range;
    val_t                 beam_intensity;
    logic                 last_beam;
  } lss_beam_t;

  typedef struct packed {
    logic [RUN_FIRST_W-1:0] run_first;
    logic [RUN_END_W-1:0]   run_end;
    val_t                   run_range_min;
    val_t                   run_range_max;
    val_t                   run_peak_intensity;
  } lss_run_t;

  typedef struct packed {
    val_t                 range_low;
    val_t                 range_high;
    val_t                 jump_limit;
    logic [MIN_RUN_W-1:0] min_run_beams;
  } lss_cfg_t;

  // segmentation state carried from beam to beam
  typedef struct packed {
    val_t prev_range;
    val_t prev_intensity;
    logic prev_valid;
    logic prev_cont;
    cnt_t run_len;
    val_t run_low;
    val_t run_high;
    val_t run_peak;
  } lss_scan_t;

  function automatic val_t med3(input val_t a, input val_t b, input val_t c);
    val_t lo;
    val_t hi;
    val_t mid;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    mid = (hi < c) ? hi : c;
    return (lo > mid) ? lo : mid;
  endfunction

  function automatic logic run_long(input cnt_t len, input logic [MIN_RUN_W-1:0] min_len);
    return 32'(len) > 32'(min_len);
  endfunction

  // run descriptor closing at end_v, end saturated at MAX_BEAMS
  function automatic lss_run_t put_run(input cnt_t end_v, input lss_scan_t st);
    cnt_t     e;
    cnt_t     len;
    cnt_t     first;
    lss_run_t res;
    e     = (end_v > CNT_W'(MAX_BEAMS)) ? CNT_W'(MAX_BEAMS) : end_v;
    len   = (st.run_len > e) ? e : st.run_len;
    first = e - len;
    res.run_first          = RUN_FIRST_W'(first);
    res.run_end            = RUN_END_W'(e);
    res.run_range_min      = st.run_low;
    res.run_range_max      = st.run_high;
    res.run_peak_intensity = st.run_peak;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/lss_judge.sv =====
`default_nettype none

// Judges one filtered beam against the previous one: extends, opens or
// closes a run.
module lss_judge (
  input  var lss_pkg::lss_cfg_t  cfg_i,
  input  var lss_pkg::lss_scan_t st_i,
  input  var lss_pkg::val_t      range_i,
  input  var lss_pkg::val_t      intensity_i,
  input  var lss_pkg::cnt_t      end_i,
  output lss_pkg::lss_scan_t     st_o,
  output logic                   emit_o,
  output lss_pkg::lss_run_t      run_o
);

  logic          in_window;
  logic          near;
  lss_pkg::val_t step;

  always_comb begin
    in_window = (range_i >= cfg_i.range_low) && (range_i <= cfg_i.range_high);
    step      = (range_i >= st_i.prev_range) ? (range_i - st_i.prev_range)
                                             : (st_i.prev_range - range_i);
    near      = st_i.prev_valid && in_window && (step <= cfg_i.jump_limit);

    st_o   = st_i;
    emit_o = 1'b0;
    if (near) begin
      if (!st_i.prev_cont) begin
        st_o.run_low  = st_i.prev_range;
        st_o.run_high = st_i.prev_range;
        st_o.run_peak = st_i.prev_intensity;
        st_o.run_len  = lss_pkg::CNT_W'(1);
      end
      if (range_i < st_o.run_low)      st_o.run_low  = range_i;
      if (range_i > st_o.run_high)     st_o.run_high = range_i;
      if (intensity_i > st_o.run_peak) st_o.run_peak = intensity_i;
      if (st_o.run_len < lss_pkg::CNT_W'(lss_pkg::MAX_BEAMS)) begin
        st_o.run_len = st_o.run_len + lss_pkg::CNT_W'(1);
      end
    end else if (st_i.prev_cont) begin
      emit_o       = lss_pkg::run_long(st_i.run_len, cfg_i.min_run_beams);
      st_o.run_len = '0;
    end
    st_o.prev_range     = range_i;
    st_o.prev_intensity = intensity_i;
    st_o.prev_valid     = in_window;
    st_o.prev_cont      = near;

    // closing run uses the statistics held before this beam
    run_o = lss_pkg::put_run(end_i, st_i);
  end

endmodule

`default_nettype wire

// ===== src/lidar_scan_segmenter.sv =====
`default_nettype none

// A beam is held in the input register and processed from there; any run it closes
// is registered in the output register (or the skid register) and shows on run_valid_o.
// Throughput: one beam per cycle; beam_stall_o rises only while both the output
// register and the skid register hold runs.
// Reset (rst_ni low, async): config registers return to defaults, valid flags and scan state cleared.

module lidar_scan_segmenter (
  input  var logic               clk_i,
  input  var logic               rst_ni,

  input  var lss_pkg::lss_beam_t beam_i,
  input  var logic               beam_valid_i,
  output logic                   beam_stall_o,

  output lss_pkg::lss_run_t      run_o,
  output logic                   run_valid_o,
  input  var logic               run_stall_i,

  input  var logic               psel,
  input  var logic               penable,
  input  var logic               pwrite,
  input  var logic [3:0]         paddr,
  input  var logic [31:0]        pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers (APB, zero wait states)
  // ---------------------------------------------------------------------------
  lss_pkg::lss_cfg_t cfg_q;
  lss_pkg::lss_cfg_t cfg_d;
  lss_pkg::lss_reg_e reg_sel;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = lss_pkg::lss_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        lss_pkg::REG_RANGE_LOW:  cfg_d.range_low     = pwdata[lss_pkg::VAL_W-1:0];
        lss_pkg::REG_RANGE_HIGH: cfg_d.range_high    = pwdata[lss_pkg::VAL_W-1:0];
        lss_pkg::REG_JUMP_LIMIT: cfg_d.jump_limit    = pwdata[lss_pkg::VAL_W-1:0];
        lss_pkg::REG_MIN_RUN:    cfg_d.min_run_beams = pwdata[lss_pkg::MIN_RUN_W-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lss_pkg::REG_RANGE_LOW:  prdata = 32'(cfg_q.range_low);
      lss_pkg::REG_RANGE_HIGH: prdata = 32'(cfg_q.range_high);
      lss_pkg::REG_JUMP_LIMIT: prdata = 32'(cfg_q.jump_limit);
      lss_pkg::REG_MIN_RUN:    prdata = 32'(cfg_q.min_run_beams);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register. It advances whenever the skid slot is free, so the only
  // backpressure is a full output pair.
  // ---------------------------------------------------------------------------
  lss_pkg::lss_beam_t in_q;
  logic               in_valid_q;
  logic               in_valid_d;
  logic               beam_accept;
  logic               proc;

  logic               skid_valid_q;
  logic               skid_valid_d;
  lss_pkg::lss_run_t  skid_q;
  logic               out_valid_q;
  logic               out_valid_d;
  lss_pkg::lss_run_t  out_q;

  assign proc         = in_valid_q && !skid_valid_q;
  assign beam_stall_o = in_valid_q && skid_valid_q;
  assign beam_accept  = beam_valid_i && !beam_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (beam_accept)   in_valid_d = 1'b1;
    else if (proc)     in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (beam_accept) in_q <= beam_i;
  end

  // ---------------------------------------------------------------------------
  // Per-beam work: median of the previous beam, judge it; on the last beam
  // also judge the raw last beam and flush an open run, then clear the scan.
  // ---------------------------------------------------------------------------
  lss_pkg::val_t     win_rng0_q, win_rng1_q, win_int0_q, win_int1_q;
  lss_pkg::cnt_t     beam_idx_q;
  lss_pkg::cnt_t     beam_idx_d;
  lss_pkg::lss_scan_t scan_q;
  lss_pkg::lss_scan_t scan_d;

  lss_pkg::val_t     med_rng;
  lss_pkg::val_t     med_int;
  lss_pkg::cnt_t     end_prev;
  lss_pkg::cnt_t     end_tail;
  lss_pkg::lss_scan_t st_prev;
  lss_pkg::lss_scan_t st_mid;
  lss_pkg::lss_scan_t st_last;
  logic              emit_prev;
  logic              emit_last;
  logic              judged;
  logic              hit_prev;
  logic              tail_ok;
  lss_pkg::lss_run_t run_prev;
  lss_pkg::lss_run_t run_last;
  lss_pkg::lss_run_t run_tail;
  lss_pkg::lss_run_t res;
  logic              res_valid;

  // first beam of a scan has no left neighbor, so beam 0 is passed through raw
  assign med_rng  = (beam_idx_q == lss_pkg::CNT_W'(1)) ? win_rng0_q :
                    lss_pkg::med3(win_rng1_q, win_rng0_q, in_q.beam_range);
  assign med_int  = (beam_idx_q == lss_pkg::CNT_W'(1)) ? win_int0_q :
                    lss_pkg::med3(win_int1_q, win_int0_q, in_q.beam_intensity);
  assign end_prev = beam_idx_q - lss_pkg::CNT_W'(1);
  assign end_tail = beam_idx_q + lss_pkg::CNT_W'(1);
  assign judged   = (beam_idx_q != '0);

  lss_judge u_judge_prev (
    .cfg_i       (cfg_q),
    .st_i        (scan_q),
    .range_i     (med_rng),
    .intensity_i (med_int),
    .end_i       (end_prev),
    .st_o        (st_prev),
    .emit_o      (emit_prev),
    .run_o       (run_prev)
  );

  assign st_mid   = judged ? st_prev : scan_q;
  assign hit_prev = judged && emit_prev;

  // last beam of a scan has no right neighbor: judged with its raw values
  lss_judge u_judge_last (
    .cfg_i       (cfg_q),
    .st_i        (st_mid),
    .range_i     (in_q.beam_range),
    .intensity_i (in_q.beam_intensity),
    .end_i       (beam_idx_q),
    .st_o        (st_last),
    .emit_o      (emit_last),
    .run_o       (run_last)
  );

  assign run_tail = lss_pkg::put_run(end_tail, st_last);
  assign tail_ok  = st_last.prev_cont && lss_pkg::run_long(st_last.run_len, cfg_q.min_run_beams);

  // at most one run per beam: the earliest one wins
  always_comb begin
    res       = run_prev;
    res_valid = 1'b0;
    if (proc) begin
      if (in_q.last_beam) begin
        priority if (hit_prev) begin
          res       = run_prev;
          res_valid = 1'b1;
        end else if (emit_last) begin
          res       = run_last;
          res_valid = 1'b1;
        end else if (tail_ok) begin
          res       = run_tail;
          res_valid = 1'b1;
        end else begin
          res_valid = 1'b0;
        end
      end else begin
        res_valid = hit_prev;
      end
    end
  end

  always_comb begin
    scan_d     = scan_q;
    beam_idx_d = beam_idx_q;
    if (proc) begin
      if (in_q.last_beam) begin
        scan_d     = '0;
        beam_idx_d = '0;
      end else begin
        scan_d = st_mid;
        if (beam_idx_q < lss_pkg::CNT_W'(lss_pkg::MAX_BEAMS)) begin
          beam_idx_d = end_tail;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid slot
  // ---------------------------------------------------------------------------
  logic out_free;

  assign out_free    = !out_valid_q || !run_stall_i;
  assign run_o       = out_q;
  assign run_valid_o = out_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid;
      end
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q)   out_q <= skid_q;
      else if (res_valid) out_q <= res;
    end else if (res_valid) begin
      skid_q <= res;
    end
    if (proc && !in_q.last_beam) begin
      win_rng1_q <= win_rng0_q;
      win_rng0_q <= in_q.beam_range;
      win_int1_q <= win_int0_q;
      win_int0_q <= in_q.beam_intensity;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_low     <= 16'd50;
      cfg_q.range_high    <= 16'd20000;
      cfg_q.jump_limit    <= 16'd100;
      cfg_q.min_run_beams <= 11'd10;
      in_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
      skid_valid_q        <= 1'b0;
      beam_idx_q          <= '0;
      scan_q              <= '0;
    end else begin
      cfg_q        <= cfg_d;
      in_valid_q   <= in_valid_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
      beam_idx_q   <= beam_idx_d;
      scan_q       <= scan_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a run while output register is empty");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beam_idx_q <= lss_pkg::CNT_W'(lss_pkg::MAX_BEAMS))
    else $error("beam index past saturation");

  a_open_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q.prev_cont |-> (scan_q.run_len != '0))
    else $error("open run with zero length");

  a_scan_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_q.last_beam) |=> (beam_idx_q == '0) && !scan_q.prev_cont)
    else $error("scan state not cleared after last beam");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !skid_valid_q)
    else $error("run produced with no free slot");

endmodule

`default_nettype wire
